[rtl/fkr_pkg.sv]
// ----------------------------------------------------------------------------
// Floor key range map table package
// Shared types, command codes and idle result values for the board table.
// ----------------------------------------------------------------------------
package fkr_pkg;

    localparam int BOARD_COUNT_DEF = 8;

    localparam logic [7:0]        KEY_BAD   = 8'hff;
    localparam logic signed [7:0] FLOOR_BAD = 8'sh7f;
    localparam logic [7:0]        BOARD_BAD = 8'hff;
    localparam logic [15:0]       LAMP_NONE = 16'hffff;

    typedef enum logic [2:0] {
        KIND_ADD = 3'd0,
        KIND_F2K = 3'd1,
        KIND_K2F = 3'd2,
        KIND_F2B = 3'd3,
        KIND_SET = 3'd4,
        KIND_GET = 3'd5
    } t_kind;

    typedef struct packed {
        logic [7:0]        id;
        logic [7:0]        first_key;
        logic signed [7:0] first_floor;
        logic [7:0]        count;
        logic [15:0]       lamps;
    } t_entry;

    typedef struct packed {
        logic              id_hit;
        logic              free;
        logic              range_hit;
        logic              le;
        logic              lt;
        logic              kf_in;
        logic [7:0]        key_val;
        logic signed [7:0] kf_floor;
    } t_match;

endpackage

[rtl/fkr_table.sv]
// ----------------------------------------------------------------------------
// Board table store
// One write port and one registered read port; entries never written read
// as zero through per-entry valid bits cleared at reset.
// ----------------------------------------------------------------------------
module fkr_table #(
    parameter int BOARD_COUNT = fkr_pkg::BOARD_COUNT_DEF,
    localparam int IDX_W = (BOARD_COUNT > 1) ? $clog2(BOARD_COUNT) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [IDX_W-1:0]   i_rd_addr,
    output fkr_pkg::t_entry    o_rd_data,
    input  logic               i_wr_en,
    input  logic [IDX_W-1:0]   i_wr_addr,
    input  fkr_pkg::t_entry    i_wr_data
);

    fkr_pkg::t_entry         r_mem [BOARD_COUNT];
    logic [BOARD_COUNT-1:0]  r_valid;
    fkr_pkg::t_entry         r_rd_data;
    logic                    r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

[rtl/fkr_match.sv]
// ----------------------------------------------------------------------------
// Board entry evaluator
// Compares one table entry against the command in hand: id and free tests,
// floor range test, key and floor arithmetic, and sort position compares.
// ----------------------------------------------------------------------------
module fkr_match (
    input  fkr_pkg::t_entry    i_entry,
    input  logic signed [7:0]  i_floor,
    input  logic [7:0]         i_key,
    input  logic [7:0]         i_id,
    input  logic signed [7:0]  i_new_floor,
    output fkr_pkg::t_match    o_match
);

    logic signed [7:0] w_sf;
    logic signed [7:0] w_ef0;
    logic signed [7:0] w_ef;
    logic [7:0]        w_ef0_u;
    logic              w_floor_pos;
    logic [8:0]        w_key_end;

    assign w_sf        = i_entry.first_floor;
    assign w_ef0_u     = i_entry.first_floor + i_entry.count;
    assign w_ef0       = $signed(w_ef0_u);
    assign w_ef        = (w_sf < 0 && w_ef0 >= 0) ? w_ef0 + 8'sd1 : w_ef0;
    assign w_floor_pos = !i_floor[7] && (i_floor != 8'sd0);
    assign w_key_end   = {1'b0, i_entry.first_key} + {1'b0, i_entry.count};

    always_comb begin
        o_match.id_hit    = (i_entry.id == i_id);
        o_match.free      = (i_entry.id == 8'd0);
        o_match.range_hit = (i_floor != 8'sd0) && (i_floor >= w_sf) && (i_floor <= w_ef);
        o_match.le        = (w_sf <= i_new_floor);
        o_match.lt        = (w_sf < i_new_floor);
        o_match.kf_in     = ({1'b0, i_key} >= {1'b0, i_entry.first_key})
                            && ({1'b0, i_key} < w_key_end);
        o_match.key_val   = 8'(i_floor) - 8'(w_sf)
                            - {7'd0, (w_floor_pos && w_sf < 0)} + i_entry.first_key;
        o_match.kf_floor  = $signed(8'(w_sf) + i_key - i_entry.first_key);
    end

endmodule

[rtl/floor_key_range_map_table_top.sv]
// ----------------------------------------------------------------------------
// Floor key range map table
// Board table with add, floor/key lookups and lamp word access.
// ----------------------------------------------------------------------------
// The input channel (i_in_valid, o_in_ready) carries one command word; the
// output channel (o_out_valid, i_out_ready) returns one result word for
// every command. Commands are taken one at a time.
// Every command walks the table one entry a cycle through the single read
// port and the shared entry evaluator. An add that moves entries reads each
// entry moved and writes it one place along, then writes the new entry.
// A new command is taken while an earlier result still waits; when the
// receiver stalls, the next result is held back until the word is taken.
// Reset clears the valid bits of the table at once, so every entry reads as
// zero; no clearing pass is needed and a command is taken as soon as reset
// is released.
// ----------------------------------------------------------------------------
module floor_key_range_map_table_top #(
    parameter int BOARD_COUNT = fkr_pkg::BOARD_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_kind,
    input  logic [7:0]         i_board_id,
    input  logic [7:0]         i_base_key,
    input  logic signed [7:0]  i_base_floor,
    input  logic [7:0]         i_floor_count,
    input  logic [15:0]        i_lamp_word,
    input  logic signed [7:0]  i_floor,
    input  logic [7:0]         i_key,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_ok,
    output logic [7:0]         o_key_out,
    output logic signed [7:0]  o_floor_out,
    output logic [7:0]         o_board_out,
    output logic [15:0]        o_lamp_out
);

    localparam int IDX_W = (BOARD_COUNT > 1) ? $clog2(BOARD_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(BOARD_COUNT - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EVAL,
        S_SH_RD,
        S_SH_WR,
        S_PUT,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [2:0]         r_kind;
    logic [7:0]         r_id;
    logic [7:0]         r_base_key;
    logic signed [7:0]  r_new_floor;
    logic [7:0]         r_count;
    logic [15:0]        r_lamp;
    logic signed [7:0]  r_floor;
    logic [7:0]         r_key;

    logic [IDX_W-1:0]   r_addr;
    logic               r_issue;
    logic               r_dv;
    logic [IDX_W-1:0]   r_didx;
    logic               r_found;
    logic [IDX_W-1:0]   r_free;
    logic [IDX_W-1:0]   r_pos;
    logic [IDX_W-1:0]   r_j;
    logic               r_up;

    logic               r_res_ok;
    logic [7:0]         r_res_key;
    logic signed [7:0]  r_res_floor;
    logic [7:0]         r_res_board;
    logic [15:0]        r_res_lamp;

    logic               r_out_valid;
    logic               r_ok;
    logic [7:0]         r_key_out;
    logic signed [7:0]  r_floor_out;
    logic [7:0]         r_board_out;
    logic [15:0]        r_lamp_out;

    logic [IDX_W-1:0]   w_rd_addr;
    fkr_pkg::t_entry    w_rd_entry;
    logic               w_wr_en;
    logic [IDX_W-1:0]   w_wr_addr;
    fkr_pkg::t_entry    w_wr_data;
    fkr_pkg::t_match    w_match;
    logic               w_accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_ok        = r_ok;
    assign o_key_out   = r_key_out;
    assign o_floor_out = r_floor_out;
    assign o_board_out = r_board_out;
    assign o_lamp_out  = r_lamp_out;

    assign w_rd_addr = (r_state == S_SH_RD) ? r_j : r_addr;

    fkr_table #(
        .BOARD_COUNT (BOARD_COUNT)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_entry),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    fkr_match u_match (
        .i_entry     (w_rd_entry),
        .i_floor     (r_floor),
        .i_key       (r_key),
        .i_id        (r_id),
        .i_new_floor (r_new_floor),
        .o_match     (w_match)
    );

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_didx;
        w_wr_data = w_rd_entry;
        unique case (r_state)
            S_SCAN: begin
                if (r_dv && r_kind == fkr_pkg::KIND_SET && w_match.id_hit) begin
                    w_wr_en         = 1'b1;
                    w_wr_data.lamps = r_lamp;
                end
            end
            S_SH_WR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_up ? r_j + 1'b1 : r_j - 1'b1;
            end
            S_PUT: begin
                w_wr_en               = 1'b1;
                w_wr_addr             = r_pos;
                w_wr_data.id          = r_id;
                w_wr_data.first_key   = r_base_key;
                w_wr_data.first_floor = r_new_floor;
                w_wr_data.count       = r_count;
                w_wr_data.lamps       = r_lamp;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_issue     <= 1'b0;
            r_dv        <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_kind      <= i_kind;
                        r_id        <= i_board_id;
                        r_base_key  <= i_base_key;
                        r_new_floor <= (i_base_floor == 8'sd0) ? 8'sd1 : i_base_floor;
                        r_count     <= i_floor_count;
                        r_lamp      <= i_lamp_word;
                        r_floor     <= i_floor;
                        r_key       <= i_key;
                        r_addr      <= '0;
                        r_issue     <= 1'b1;
                        r_dv        <= 1'b0;
                        r_found     <= 1'b0;
                        r_free      <= '0;
                        r_pos       <= '0;
                        r_res_ok    <= 1'b0;
                        r_res_key   <= fkr_pkg::KEY_BAD;
                        r_res_floor <= fkr_pkg::FLOOR_BAD;
                        r_res_board <= fkr_pkg::BOARD_BAD;
                        r_res_lamp  <= fkr_pkg::LAMP_NONE;
                        r_state     <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_dv   <= r_issue;
                    r_didx <= r_addr;
                    if (r_issue) begin
                        if (r_addr == LAST) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_addr <= r_addr + 1'b1;
                        end
                    end
                    if (r_dv) begin
                        case (r_kind)
                            fkr_pkg::KIND_ADD: begin
                                if (!r_found && w_match.free) begin
                                    r_found <= 1'b1;
                                    r_free  <= r_didx;
                                end else if (r_found ? w_match.lt : w_match.le) begin
                                    r_pos <= r_pos + 1'b1;
                                end
                            end
                            fkr_pkg::KIND_F2K: begin
                                if (!r_found && w_match.range_hit) begin
                                    r_found   <= 1'b1;
                                    r_res_key <= w_match.key_val;
                                end
                            end
                            fkr_pkg::KIND_F2B: begin
                                if (!r_found && w_match.range_hit) begin
                                    r_found     <= 1'b1;
                                    r_res_board <= w_rd_entry.id;
                                end
                            end
                            fkr_pkg::KIND_K2F: begin
                                if (!r_found && w_match.id_hit) begin
                                    r_found     <= 1'b1;
                                    r_res_floor <= w_match.kf_in ? w_match.kf_floor
                                                                 : fkr_pkg::FLOOR_BAD;
                                end
                            end
                            fkr_pkg::KIND_GET: begin
                                if (!r_found && w_match.id_hit) begin
                                    r_found    <= 1'b1;
                                    r_res_lamp <= w_rd_entry.lamps;
                                end
                            end
                            default: begin
                            end
                        endcase
                        if (!r_issue) begin
                            r_state <= S_EVAL;
                        end
                    end
                end
                S_EVAL: begin
                    r_dv <= 1'b0;
                    r_up <= (r_pos < r_free);
                    if (r_kind == fkr_pkg::KIND_ADD && r_found) begin
                        if (r_pos < r_free) begin
                            r_j     <= r_free - 1'b1;
                            r_state <= S_SH_RD;
                        end else if (r_pos > r_free) begin
                            r_j     <= r_free + 1'b1;
                            r_state <= S_SH_RD;
                        end else begin
                            r_state <= S_PUT;
                        end
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_SH_RD: begin
                    r_state <= S_SH_WR;
                end
                S_SH_WR: begin
                    if (r_j == r_pos) begin
                        r_state <= S_PUT;
                    end else begin
                        r_j     <= r_up ? r_j - 1'b1 : r_j + 1'b1;
                        r_state <= S_SH_RD;
                    end
                end
                S_PUT: begin
                    r_res_ok <= 1'b1;
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_ok        <= r_res_ok;
                        r_key_out   <= r_res_key;
                        r_floor_out <= r_res_floor;
                        r_board_out <= r_res_board;
                        r_lamp_out  <= r_res_lamp;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_write_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> ((r_state == S_SCAN && r_kind == fkr_pkg::KIND_SET)
                     || r_state == S_SH_WR || r_state == S_PUT))
        else $error("table written outside lamp update, move or insert");

    a_move_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SH_WR) |-> (r_up ? (r_j >= r_pos && r_j < r_free)
                                       : (r_j <= r_pos && r_j > r_free)))
        else $error("entry move index outside the span being shifted");

    a_accept_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_SCAN))
        else $error("accepted command did not start a table walk");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result word raised outside the completion state");

    a_put_after_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT) |-> (r_kind == fkr_pkg::KIND_ADD && r_found))
        else $error("insert without an add that found a free entry");
`endif

endmodule
